[src/hscfi_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types of the handshake I/O card with flag and interrupt logic.
package hscfi_pkg;

  localparam int unsigned SignalCount = 15;
  localparam int unsigned WordWidth   = 16;
  localparam int unsigned TicksWidth  = 8;

  localparam int unsigned SigClf   = 0;
  localparam int unsigned SigStf   = 1;
  localparam int unsigned SigEnf   = 2;
  localparam int unsigned SigSfc   = 3;
  localparam int unsigned SigSfs   = 4;
  localparam int unsigned SigIoi   = 5;
  localparam int unsigned SigIoo   = 6;
  localparam int unsigned SigPopio = 7;
  localparam int unsigned SigCrs   = 8;
  localparam int unsigned SigClc   = 9;
  localparam int unsigned SigStc   = 10;
  localparam int unsigned SigSir   = 11;
  localparam int unsigned SigIak   = 12;
  localparam int unsigned SigIen   = 13;
  localparam int unsigned SigPrh   = 14;

  typedef enum logic [1:0] {
    CfgDiagnosticMode = 2'd0,
    CfgEarlyCpu       = 2'd1,
    CfgLoopbackTicks  = 2'd2
  } cfg_index_e;

  typedef enum logic {
    OpBusCycle = 1'b0,
    OpTick     = 1'b1
  } operation_e;

  typedef struct packed {
    logic [2:0]           pad;
    logic                 priority_low;
    logic                 flag_out;
    logic                 interrupt_request;
    logic                 service_request;
    logic                 skip_on_flag;
    logic [WordWidth-1:0] data_out;
  } result_t;

endpackage

[src/handshake_io_card_flag_interrupt_top.sv]
`timescale 1ns / 1ps
// Top level of the handshake I/O card with flag, interrupt and loopback logic.
//
//  Channel  Direction  Handshake                     Payload
//  s_axis   in         s_axis_tvalid/s_axis_tready   tdata: signal_set, data_in; tuser: operation
//  m_axis   out        m_axis_tvalid/m_axis_tready   tdata: data_out and five status bits
//  cfg      in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One item is accepted per clock cycle while the skid register is empty; its result is registered before it leaves.
// The card state is updated in the cycle of the transfer by one pass of shallow logic.
// A result register and a skid register let one more item in while a result stalls.
// Reset clears the data registers, command, control and flag, sets the flag buffer,
// and loads diagnostic_mode 0, early_cpu 0 and loopback_ticks 1.
module handshake_io_card_flag_interrupt_top #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [14:0] signal_set, [30:15] data_in, [31] zero
  input  logic        s_axis_tuser,  // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] data_out, [16] skip_on_flag,
                                     // [17] service_request, [18] interrupt_request,
                                     // [19] flag_out, [20] priority_low, [23:21] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned Tw = hscfi_pkg::TicksWidth;
  localparam int unsigned Ww = hscfi_pkg::WordWidth;

  logic                   diag_q;
  logic                   early_q;
  logic [Tw-1:0]          ticks_q;

  logic [DATA_WIDTH-1:0]  out_reg_q, out_reg_d;
  logic [DATA_WIDTH-1:0]  in_reg_q, in_reg_d;
  logic                   command_q, command_d;
  logic                   control_q, control_d;
  logic                   flag_q, flag_d;
  logic                   flag_buf_q, flag_buf_d;
  logic [Tw-1:0]          loop_cnt_q, loop_cnt_d;
  logic                   loop_pend_q, loop_pend_d;

  hscfi_pkg::result_t     res;
  hscfi_pkg::result_t     out_data_q;
  hscfi_pkg::result_t     skid_data_q;
  logic                   out_valid_q;
  logic                   skid_valid_q;

  logic [hscfi_pkg::SignalCount-1:0] sigs;
  logic [Ww-1:0]                     word;
  logic                              accept;
  logic                              drain;

  assign sigs          = s_axis_tdata[hscfi_pkg::SignalCount-1:0];
  assign word          = s_axis_tdata[hscfi_pkg::SignalCount +: Ww];
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign drain         = out_valid_q && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    logic [Tw-1:0] eff;
    logic          cn_irq;
    logic          cn_prl;
    logic          ien;
    logic          dma;
    eff         = (ticks_q == '0) ? Tw'(1) : ticks_q;
    cn_irq      = 1'b0;
    cn_prl      = 1'b0;
    ien         = 1'b0;
    dma         = sigs[hscfi_pkg::SigIoi] || sigs[hscfi_pkg::SigIoo];
    out_reg_d   = out_reg_q;
    in_reg_d    = in_reg_q;
    command_d   = command_q;
    control_d   = control_q;
    flag_d      = flag_q;
    flag_buf_d  = flag_buf_q;
    loop_cnt_d  = loop_cnt_q;
    loop_pend_d = loop_pend_q;
    res         = '0;

    if (s_axis_tuser == hscfi_pkg::OpTick) begin
      if (loop_pend_q) begin
        loop_cnt_d = loop_cnt_q - Tw'(1);
        if (loop_cnt_d == '0) begin
          loop_pend_d = 1'b0;
          if (diag_q) begin
            command_d  = 1'b0;
            flag_buf_d = 1'b1;
            flag_d     = 1'b1;
          end
        end
      end
    end else begin
      if (sigs[hscfi_pkg::SigClf]) begin
        flag_buf_d = 1'b0;
        flag_d     = 1'b0;
      end
      if (sigs[hscfi_pkg::SigStf]) begin
        flag_buf_d = 1'b1;
      end
      if (sigs[hscfi_pkg::SigEnf] && flag_buf_d) begin
        flag_d = 1'b1;
      end
      if (sigs[hscfi_pkg::SigSfc] && !flag_d) begin
        res.skip_on_flag = 1'b1;
      end
      if (sigs[hscfi_pkg::SigSfs] && flag_d) begin
        res.skip_on_flag = 1'b1;
      end
      if (sigs[hscfi_pkg::SigIoi]) begin
        res.data_out = Ww'(in_reg_d);
      end
      if (sigs[hscfi_pkg::SigIoo]) begin
        out_reg_d = DATA_WIDTH'(word);
      end
      if (sigs[hscfi_pkg::SigPopio]) begin
        flag_buf_d = 1'b1;
        out_reg_d  = '0;
      end
      if (sigs[hscfi_pkg::SigCrs]) begin
        control_d   = 1'b0;
        command_d   = 1'b0;
        loop_pend_d = 1'b0;
        loop_cnt_d  = '0;
      end
      if (sigs[hscfi_pkg::SigClc]) begin
        control_d = 1'b0;
        command_d = 1'b0;
        if (loop_pend_d && loop_cnt_d == eff) begin
          loop_pend_d = 1'b0;
          loop_cnt_d  = '0;
        end
      end
      if (sigs[hscfi_pkg::SigStc]) begin
        control_d = 1'b1;
        command_d = 1'b1;
        if (diag_q && (!early_q || !dma)) begin
          in_reg_d    = out_reg_d;
          loop_pend_d = 1'b1;
          loop_cnt_d  = eff;
        end
      end
      if (sigs[hscfi_pkg::SigSir]) begin
        cn_prl = !(control_d && flag_d);
        cn_irq = control_d && flag_d && flag_buf_d;
        res.service_request = flag_d;
      end
      if (sigs[hscfi_pkg::SigIak]) begin
        flag_buf_d = 1'b0;
      end
      if (sigs[hscfi_pkg::SigIen]) begin
        ien = 1'b1;
      end
      if (sigs[hscfi_pkg::SigPrh]) begin
        res.interrupt_request = ien && cn_irq;
        res.flag_out          = ien && cn_irq;
        res.priority_low      = !ien || cn_prl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_q  <= 1'b0;
      early_q <= 1'b0;
      ticks_q <= Tw'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hscfi_pkg::CfgDiagnosticMode: diag_q  <= cfg_data_i[0];
        hscfi_pkg::CfgEarlyCpu:       early_q <= cfg_data_i[0];
        hscfi_pkg::CfgLoopbackTicks:  ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_reg_q   <= '0;
      in_reg_q    <= '0;
      command_q   <= 1'b0;
      control_q   <= 1'b0;
      flag_q      <= 1'b0;
      flag_buf_q  <= 1'b1;
      loop_cnt_q  <= '0;
      loop_pend_q <= 1'b0;
    end else if (accept) begin
      out_reg_q   <= out_reg_d;
      in_reg_q    <= in_reg_d;
      command_q   <= command_d;
      control_q   <= control_d;
      flag_q      <= flag_d;
      flag_buf_q  <= flag_buf_d;
      loop_cnt_q  <= loop_cnt_d;
      loop_pend_q <= loop_pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || drain) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || drain) begin
      out_data_q <= skid_valid_q ? skid_data_q : res;
    end else if (accept) begin
      skid_data_q <= res;
    end
  end

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid register holds a result while the output register is empty.");

  a_pending_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loop_pend_q == (loop_cnt_q != '0))
    else $error("Loopback pending flag disagrees with the countdown.");

  a_tick_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == hscfi_pkg::OpTick && !out_valid_q) |=> m_axis_tdata == '0)
    else $error("A tick transfer produced a nonzero result.");

  a_irq_with_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.interrupt_request == out_data_q.flag_out)
    else $error("Interrupt request and flag output differ.");
`endif

endmodule
